[design/lbtdd_pkg.sv]
// ----------------------------------------------------------------------------
// lbtdd_pkg: shared types and constants of the binary to decimal converter
// Field widths, register reset value and the controller state encoding.
// ----------------------------------------------------------------------------
package lbtdd_pkg;

    // field widths
    localparam int BYTE_W  = 8;
    localparam int DIGIT_W = 4;
    localparam int LEN_W   = 7;

    // output length register reset value
    localparam logic [LEN_W-1:0] LEN_RESET = 7'd40;

    // divisor of each bit-serial pass
    localparam logic [DIGIT_W:0] TEN = 5'd10;

    // controller states
    typedef enum logic [1:0] {
        ST_LOAD,
        ST_FETCH,
        ST_DIV,
        ST_EMIT
    } state_t;

endpackage

[design/le_binary_to_decimal_digits_top.sv]
// ----------------------------------------------------------------------------
// le_binary_to_decimal_digits_top: little-endian binary to decimal digits
// Usage:
//   Input channel (byte_valid / byte_stall) carries one byte of an unsigned
//   number per transfer, least significant byte first; last_byte marks the
//   final byte. Up to MAX_BYTES bytes are kept; a longer number gives a
//   single empty result.
//   Output channel (digit_valid / digit_stall) carries one decimal digit per
//   transfer, most significant first, at most output_length - 1 of the
//   MAX_DIGITS least significant digits; last_digit marks the final one.
//   cfg_we / cfg_wdata write output_length (reset 40) while idle.
// Flow:
//   bytes load at one per cycle while byte_stall is low. After the last
//   byte the number is divided by ten bit-serially through a 4-bit
//   remainder unit, one pass per digit. Digits then leave at one per
//   cycle while the receiver does not stall. Empty, zero and too-long
//   results come out in the cycle after the last byte is taken.
// Reset clears the controller, the byte count and the output register.
// While the receiver stalls a pending digit, the output register holds and no new byte or
// digit is taken.
// ----------------------------------------------------------------------------
module le_binary_to_decimal_digits_top #(
    parameter int MAX_BYTES  = 24,
    parameter int MAX_DIGITS = 39
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [lbtdd_pkg::LEN_W-1:0]   cfg_wdata,
    input  logic                          byte_valid,
    output logic                          byte_stall,
    input  logic [lbtdd_pkg::BYTE_W-1:0]  value_byte,
    input  logic                          last_byte,
    output logic                          digit_valid,
    input  logic                          digit_stall,
    output logic [lbtdd_pkg::DIGIT_W-1:0] digit,
    output logic                          empty_res,
    output logic                          last_digit
);
    import lbtdd_pkg::*;

    localparam int PW = (MAX_BYTES > 1) ? $clog2(MAX_BYTES) : 1;
    localparam int CW = $clog2(MAX_BYTES + 1);
    localparam int DW = $clog2(MAX_DIGITS + 1);

    // registers
    state_t              state_reg, state_next;
    logic [LEN_W-1:0]    out_len_reg;
    logic [CW-1:0]       count_reg, count_next;
    logic                too_long_reg, too_long_next;
    logic                zero_reg, zero_next;
    logic [PW-1:0]       last_idx_reg, last_idx_next;
    logic [PW-1:0]       ptr_reg, ptr_next;
    logic [2:0]          bit_cnt_reg, bit_cnt_next;
    logic [DW-1:0]       ndig_reg, ndig_next;
    logic                nz_reg, nz_next;
    logic [LEN_W-1:0]    emit_left_reg, emit_left_next;
    logic                out_valid_reg, out_valid_next;
    logic [DIGIT_W-1:0]  digit_reg, digit_next;
    logic                empty_reg, empty_next;
    logic                last_reg, last_next;
    logic [DIGIT_W-1:0]  rem_reg, rem_next;
    logic [BYTE_W-1:0]   work_reg, work_next;
    logic [BYTE_W-1:0]   store_reg [MAX_BYTES];
    logic [DIGIT_W-1:0]  dstk_reg [MAX_DIGITS];

    // shared control terms
    logic                byte_take;
    logic                fits;
    logic                overflow;
    logic                all_zero;
    logic                start_conv;
    logic                pass_end;
    logic                more_digits;
    logic                out_free;
    logic                store_we;
    logic [PW-1:0]       store_wa;
    logic [BYTE_W-1:0]   store_wd;
    logic                push;
    logic                pop;

    // bit-serial divide by ten
    logic [DIGIT_W:0]    rem_sum;
    logic                quo_bit;
    logic [DIGIT_W-1:0]  rem_new;
    logic [BYTE_W-1:0]   work_new;
    logic [DW-1:0]       ndig_inc;
    logic [LEN_W-1:0]    len_lim;
    logic [LEN_W-1:0]    ndig_ext;

    assign rem_sum  = {rem_reg, work_reg[BYTE_W-1]};
    assign quo_bit  = (rem_sum >= TEN);
    assign rem_new  = quo_bit ? DIGIT_W'(rem_sum - TEN) : rem_sum[DIGIT_W-1:0];
    assign work_new = {work_reg[BYTE_W-2:0], quo_bit};
    assign ndig_inc = DW'(ndig_reg + 1'b1);
    assign len_lim  = LEN_W'(out_len_reg - 1'b1);
    assign ndig_ext = LEN_W'(ndig_inc);

    // handshake and decision terms
    assign out_free    = !out_valid_reg || !digit_stall;
    assign byte_stall  = (state_reg != ST_LOAD) || (out_valid_reg && digit_stall);
    assign byte_take   = byte_valid && !byte_stall;
    assign fits        = (count_reg < CW'(MAX_BYTES));
    assign overflow    = too_long_reg || !fits;
    assign all_zero    = zero_reg && (value_byte == '0);
    assign start_conv  = byte_take && last_byte && !overflow
                         && (out_len_reg > LEN_W'(1)) && !all_zero;
    assign pass_end    = (state_reg == ST_DIV) && (bit_cnt_reg == 3'd7)
                         && (ptr_reg == '0);
    assign more_digits = (nz_reg || quo_bit) && (ndig_reg < DW'(MAX_DIGITS - 1));

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_LOAD:
            begin
                if (start_conv)
                    state_next = ST_FETCH;
            end
            ST_FETCH:
            begin
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                if (pass_end)
                    state_next = more_digits ? ST_FETCH : ST_EMIT;
            end
            ST_EMIT:
            begin
                if (out_free && (emit_left_reg == LEN_W'(1)))
                    state_next = ST_LOAD;
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    // datapath and output values
    always_comb
    begin
        count_next     = count_reg;
        too_long_next  = too_long_reg;
        zero_next      = zero_reg;
        last_idx_next  = last_idx_reg;
        ptr_next       = ptr_reg;
        bit_cnt_next   = bit_cnt_reg;
        ndig_next      = ndig_reg;
        nz_next        = nz_reg;
        emit_left_next = emit_left_reg;
        out_valid_next = out_valid_reg && digit_stall;
        digit_next     = digit_reg;
        empty_next     = empty_reg;
        last_next      = last_reg;
        rem_next       = rem_reg;
        work_next      = work_reg;
        store_we       = 1'b0;
        store_wa       = ptr_reg;
        store_wd       = work_new;
        push           = 1'b0;
        pop            = 1'b0;
        case (state_reg)
            ST_LOAD:
            begin
                if (byte_take)
                begin
                    if (fits)
                    begin
                        store_we   = 1'b1;
                        store_wa   = count_reg[PW-1:0];
                        store_wd   = value_byte;
                        count_next = CW'(count_reg + 1'b1);
                        zero_next  = all_zero;
                    end
                    else
                    begin
                        too_long_next = 1'b1;
                    end
                    if (last_byte)
                    begin
                        count_next    = '0;
                        too_long_next = 1'b0;
                        zero_next     = 1'b1;
                        last_idx_next = count_reg[PW-1:0];
                        ptr_next      = count_reg[PW-1:0];
                        rem_next      = '0;
                        nz_next       = 1'b0;
                        ndig_next     = '0;
                        if (!start_conv)
                        begin
                            // empty, too long or zero value: one result now
                            out_valid_next = 1'b1;
                            digit_next     = '0;
                            empty_next     = overflow || (out_len_reg <= LEN_W'(1));
                            last_next      = 1'b1;
                        end
                    end
                end
            end
            ST_FETCH:
            begin
                work_next    = store_reg[ptr_reg];
                bit_cnt_next = '0;
            end
            ST_DIV:
            begin
                rem_next     = rem_new;
                work_next    = work_new;
                nz_next      = nz_reg || quo_bit;
                bit_cnt_next = 3'(bit_cnt_reg + 1'b1);
                if (bit_cnt_reg == 3'd7)
                begin
                    // quotient byte done: write back, then move down one byte or end the pass
                    store_we = 1'b1;
                    if (ptr_reg != '0)
                    begin
                        ptr_next  = PW'(ptr_reg - 1'b1);
                        work_next = store_reg[PW'(ptr_reg - 1'b1)];
                    end
                    else
                    begin
                        push      = 1'b1;
                        ndig_next = ndig_inc;
                        ptr_next  = last_idx_reg;
                        rem_next  = '0;
                        nz_next   = 1'b0;
                        emit_left_next = (ndig_ext < len_lim) ? ndig_ext : len_lim;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    digit_next     = dstk_reg[0];
                    empty_next     = 1'b0;
                    last_next      = (emit_left_reg == LEN_W'(1));
                    pop            = 1'b1;
                    emit_left_next = LEN_W'(emit_left_reg - 1'b1);
                end
            end
            default:
            begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            out_len_reg   <= LEN_RESET;
            count_reg     <= '0;
            too_long_reg  <= 1'b0;
            zero_reg      <= 1'b1;
            last_idx_reg  <= '0;
            ptr_reg       <= '0;
            bit_cnt_reg   <= '0;
            ndig_reg      <= '0;
            nz_reg        <= 1'b0;
            emit_left_reg <= '0;
            out_valid_reg <= 1'b0;
            digit_reg     <= '0;
            empty_reg     <= 1'b0;
            last_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            if (cfg_we)
                out_len_reg <= cfg_wdata;
            count_reg     <= count_next;
            too_long_reg  <= too_long_next;
            zero_reg      <= zero_next;
            last_idx_reg  <= last_idx_next;
            ptr_reg       <= ptr_next;
            bit_cnt_reg   <= bit_cnt_next;
            ndig_reg      <= ndig_next;
            nz_reg        <= nz_next;
            emit_left_reg <= emit_left_next;
            out_valid_reg <= out_valid_next;
            digit_reg     <= digit_next;
            empty_reg     <= empty_next;
            last_reg      <= last_next;
        end
    end

    // working remainder and current byte
    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        work_reg <= work_next;
    end

    // number store, at most one byte written per cycle
    always_ff @(posedge clk)
    begin
        if (store_we)
            store_reg[store_wa] <= store_wd;
    end

    // digit stack: newest remainder on top, popped most significant first
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            dstk_reg[0] <= rem_new;
            for (int i = 1; i < MAX_DIGITS; i++)
                dstk_reg[i] <= dstk_reg[i-1];
        end
        else if (pop)
        begin
            for (int i = 0; i < MAX_DIGITS - 1; i++)
                dstk_reg[i] <= dstk_reg[i+1];
        end
    end

    // output ports
    assign digit_valid = out_valid_reg;
    assign digit       = digit_reg;
    assign empty_res   = empty_reg;
    assign last_digit  = last_reg;

endmodule

[design/lbtdd_checker.sv]
// ----------------------------------------------------------------------------
// lbtdd_checker: port-level checks of the binary to decimal converter
// Watches the digit channel and the byte channel backpressure over time.
// ----------------------------------------------------------------------------
module lbtdd_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          byte_stall,
    input logic                          digit_valid,
    input logic                          digit_stall,
    input logic [lbtdd_pkg::DIGIT_W-1:0] digit,
    input logic                          empty_res,
    input logic                          last_digit
);
    import lbtdd_pkg::*;

    // stalled digit transfer holds its payload
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit_stall |=> digit_valid && $stable(digit)
            && $stable(empty_res) && $stable(last_digit))
        else $error("digit payload changed while stalled");

    // every digit is decimal
    a_digit_range: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid |-> (digit <= DIGIT_W'(9)))
        else $error("digit out of decimal range");

    // empty result is a lone zero that ends the number
    a_empty_form: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && empty_res |-> (digit == '0) && last_digit)
        else $error("empty result malformed");

    // no byte taken while a digit waits on a stalled receiver
    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        digit_valid && digit_stall |-> byte_stall)
        else $error("byte accepted while digit output stalled");

endmodule

bind le_binary_to_decimal_digits_top lbtdd_checker u_lbtdd_checker (.*);

[sim/le_binary_to_decimal_digits_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// le_binary_to_decimal_digits_top_test: testbench of the byte to digit converter
// Sends little-endian numbers byte by byte under random input gaps and output
// stalls, predicts the decimal digits of each number and checks every digit
// transfer in order. Walks the output length through zero, one, small, reset
// and full-scale settings, with one long output hold and one gap-free phase.
// ----------------------------------------------------------------------------
module le_binary_to_decimal_digits_top_test;

    import lbtdd_pkg::*;

    localparam int NUM_BYTES     = 24;
    localparam int NUM_DIGITS    = 39;
    localparam int SETTLE_CYCLES = 20;
    localparam int HOLD_CYCLES   = 400;
    localparam int PHASE_BYTES   = 37;
    localparam int NUM_PHASES    = 9;

    // one digit transfer as seen on the output port
    typedef struct packed {
        logic [DIGIT_W-1:0] digit;
        logic               empty_res;
        logic               last_digit;
    } digit_result_t;

    // ------------------------------------------------------------------------
    // predictor: collects bytes, divides by ten on the last one and keeps
    // the digits that are due, oldest first
    // ------------------------------------------------------------------------
    class decimal_predictor;
        logic [BYTE_W-1:0] held_bytes [NUM_BYTES];
        int                held;
        bit                overflowed;
        logic [LEN_W-1:0]  out_len;
        digit_result_t     due_digits [$];
        int                errors;

        function new();
            held       = 0;
            overflowed = 1'b0;
            out_len    = LEN_RESET;
            errors     = 0;
        endfunction

        function void set_length(logic [LEN_W-1:0] v);
            out_len = v;
        endfunction

        function int outstanding();
            return due_digits.size();
        endfunction

        function void add_result(logic [DIGIT_W-1:0] d, logic e, logic l);
            digit_result_t r;
            r.digit      = d;
            r.empty_res  = e;
            r.last_digit = l;
            due_digits.push_back(r);
        endfunction

        function bit is_zero(logic [BYTE_W-1:0] w [NUM_BYTES], int n);
            int i;
            for (i = 0; i < n; i++)
                if (w[i] != '0)
                    return 1'b0;
            return 1'b1;
        endfunction

        function void note_byte(logic [BYTE_W-1:0] b, logic lastb);
            logic [BYTE_W-1:0]  work [NUM_BYTES];
            logic [DIGIT_W-1:0] digits [NUM_DIGITS];
            int                 len, ndig, emit, k, i, rem, cur;
            bit                 ovf;
            if (held < NUM_BYTES)
            begin
                held_bytes[held] = b;
                held++;
            end
            else
                overflowed = 1'b1;
            if (!lastb)
                return;
            len        = held;
            ovf        = overflowed;
            held       = 0;
            overflowed = 1'b0;
            // too long or no room for any digit
            if (ovf || out_len <= 1)
            begin
                add_result('0, 1'b1, 1'b1);
                return;
            end
            for (i = 0; i < NUM_BYTES; i++)
                work[i] = (i < len) ? held_bytes[i] : '0;
            // long division by ten, most significant byte first
            ndig = 0;
            while (!is_zero(work, len) && ndig < NUM_DIGITS)
            begin
                rem = 0;
                for (i = len - 1; i >= 0; i--)
                begin
                    cur     = rem * 256 + int'(work[i]);
                    work[i] = BYTE_W'(cur / 10);
                    rem     = cur % 10;
                end
                digits[ndig] = DIGIT_W'(rem);
                ndig++;
            end
            // zero value
            if (ndig == 0)
            begin
                add_result('0, 1'b0, 1'b1);
                return;
            end
            emit = ndig;
            if (emit > int'(out_len) - 1)
                emit = int'(out_len) - 1;
            for (k = 0; k < emit; k++)
                add_result(digits[ndig - 1 - k], 1'b0, (k + 1 == emit));
        endfunction

        function void check_digit(logic [DIGIT_W-1:0] d, logic e, logic l);
            digit_result_t want;
            if (due_digits.size() == 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("unexpected digit transfer: digit %0d empty %0b last %0b",
                             d, e, l);
                return;
            end
            want = due_digits.pop_front();
            if (want.digit !== d || want.empty_res !== e || want.last_digit !== l)
            begin
                errors++;
                if (errors <= 10)
                    $display("mismatch: expected %0d/%0b/%0b got %0d/%0b/%0b",
                             want.digit, want.empty_res, want.last_digit, d, e, l);
            end
        endfunction

        function void close_out();
            if (due_digits.size() != 0)
            begin
                errors++;
                if (errors <= 10)
                    $display("%0d digits never arrived", due_digits.size());
            end
        endfunction
    endclass

    logic               clk = 1'b0;
    logic               rst_n;
    logic               cfg_we;
    logic [LEN_W-1:0]   cfg_wdata;
    logic               byte_valid;
    logic               byte_stall;
    logic [BYTE_W-1:0]  value_byte;
    logic               last_byte;
    logic               digit_valid;
    logic               digit_stall;
    logic [DIGIT_W-1:0] digit;
    logic               empty_res;
    logic               last_digit;

    decimal_predictor   conv;
    bit                 steady       = 1'b0;
    bit                 hold_request = 1'b0;

    le_binary_to_decimal_digits_top #(
        .MAX_BYTES  (NUM_BYTES),
        .MAX_DIGITS (NUM_DIGITS)
    ) dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_wdata   (cfg_wdata),
        .byte_valid  (byte_valid),
        .byte_stall  (byte_stall),
        .value_byte  (value_byte),
        .last_byte   (last_byte),
        .digit_valid (digit_valid),
        .digit_stall (digit_stall),
        .digit       (digit),
        .empty_res   (empty_res),
        .last_digit  (last_digit)
    );

    always #2 clk = ~clk;

    // gap length: mostly none or short, a few long
    function automatic int pick_gap();
        int r;
        r = $urandom_range(99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 30);
    endfunction

    // one byte transfer; valid stays high when no gap follows
    task automatic send_byte(input logic [BYTE_W-1:0] b, input logic lastb);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            byte_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        byte_valid <= 1'b1;
        value_byte <= b;
        last_byte  <= lastb;
        do
            @(posedge clk);
        while (byte_stall);
        conv.note_byte(b, lastb);
    endtask

    // one number of random size and shape
    task automatic send_number(inout int count);
        int                n, r, shape, i;
        logic [BYTE_W-1:0] b;
        r = $urandom_range(99);
        if (r < 60)
            n = $urandom_range(1, 6);
        else if (r < 85)
            n = $urandom_range(7, 16);
        else if (r < 95)
            n = $urandom_range(17, NUM_BYTES);
        else
            n = $urandom_range(NUM_BYTES + 1, NUM_BYTES + 4);
        shape = $urandom_range(9);
        for (i = 0; i < n; i++)
        begin
            case (shape)
                0:       b = '0;
                1:       b = '1;
                2:       b = (i == 0) ? BYTE_W'($urandom_range(255)) : '0;
                3:       b = (i >= n - 2) ? '0 : BYTE_W'($urandom_range(255));
                default: b = BYTE_W'($urandom_range(255));
            endcase
            send_byte(b, i == n - 1);
        end
        count += n;
    endtask

    // wait for all digits, let the block go idle
    task automatic settle();
        byte_valid <= 1'b0;
        while (conv.outstanding() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_length(input logic [LEN_W-1:0] v);
        settle();
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge clk);
        cfg_we    <= 1'b0;
        conv.set_length(v);
    endtask

    // receiver: random stalls and one long hold counted here
    initial
    begin : receiver
        int stall_left;
        int hold_left;
        stall_left = 0;
        hold_left  = 0;
        digit_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                hold_left    = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                digit_stall <= 1'b1;
            end
            else
            begin
                if (stall_left == 0)
                    stall_left = pick_gap();
                digit_stall <= (stall_left > 0);
                if (stall_left > 0)
                    stall_left--;
            end
        end
    end

    // check each digit transfer
    always @(posedge clk)
    begin
        if (rst_n && digit_valid && !digit_stall)
            conv.check_digit(digit, empty_res, last_digit);
    end

    initial
    begin : stimulus
        int               p, i, w, phase_bytes;
        logic [LEN_W-1:0] len_now;
        conv = new();
        cfg_we     <= 1'b0;
        cfg_wdata  <= '0;
        byte_valid <= 1'b0;
        value_byte <= '0;
        last_byte  <= 1'b0;
        rst_n = 1'b0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero, one full byte, and the largest number at the reset length
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        for (i = 0; i < NUM_BYTES; i++)
            send_byte(8'hFF, i == NUM_BYTES - 1);

        // random numbers under several output lengths
        for (p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:       len_now = 7'd2;
                1:       len_now = '0;
                2:       len_now = 7'd1;
                3:       len_now = '1;
                4:       len_now = 7'd64;
                5:       len_now = 7'd3;
                6:       len_now = 7'd39;
                7:       len_now = LEN_RESET;
                default: len_now = LEN_W'($urandom_range(2, 127));
            endcase
            write_length(len_now);
            steady = (p == 4);
            if (p == 3)
                hold_request = 1'b1;
            phase_bytes = 0;
            while (phase_bytes < PHASE_BYTES)
                send_number(phase_bytes);
        end
        steady = 1'b0;
        byte_valid <= 1'b0;

        // drain and look for stray digits
        for (w = 0; w < 200000 && conv.outstanding() != 0; w++)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        conv.close_out();
        if (conv.errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

    // run limit
    initial
    begin : watchdog
        #4000000;
        $display("DONE: errors detected");
        $finish;
    end

endmodule

[sim.f]
design/lbtdd_pkg.sv
design/le_binary_to_decimal_digits_top.sv
design/lbtdd_checker.sv
sim/le_binary_to_decimal_digits_top_test.sv
